FILE: hw/rtl/mlb_pkg.sv
// mlb_pkg: shared constants, types and codes for the mac learning bridge
// used by mlb_ram users, mlb_ctrl, mlb_datapath and mac_learning_bridge
`timescale 1ns / 1ps

package mlb_pkg;

    localparam int TABLE_ENTRIES    = 64;
    localparam int PORT_BITS        = 8;
    localparam int IDX_W            = $clog2(TABLE_ENTRIES);
    localparam int MAC_W            = 48;
    localparam int IN_PORT_W        = 8;
    localparam int LEN_W            = 16;
    localparam int CNT_W            = 64;
    localparam int ENTRY_W          = MAC_W + PORT_BITS;
    localparam int S_TDATA_W        = 120;
    localparam int M_TDATA_W        = 336;
    localparam int M_USED_W         = 2 + 8 + 1 + 5 * CNT_W;
    localparam logic [LEN_W-1:0] MIN_HEADER_BYTES = LEN_W'(14);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    typedef logic [MAC_W-1:0]     mac_t;
    typedef logic [PORT_BITS-1:0] port_t;
    typedef logic [IDX_W-1:0]     idx_t;
    typedef logic [CNT_W-1:0]     cnt_t;

    typedef enum logic [1:0] {
        VERDICT_PASS    = 2'd0,
        VERDICT_FORWARD = 2'd1,
        VERDICT_FLOOD   = 2'd2
    } verdict_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LAST,
        ST_COMMIT
    } state_t;

    typedef struct packed {
        logic capture;
        logic scan;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic scan_last;
    } status_t;

endpackage

FILE: hw/rtl/mac_learning_bridge.sv
// Steps: capture in ST_IDLE, scan of the mac table in ST_SCAN, compare of the last
// read in ST_LAST, result registered to m_tvalid on commit in ST_COMMIT. The scan uses
// the single read port of the table ram, one entry per cycle; no new item is taken
// before commit. A result waiting on m_tready stalls only the next item's commit.
// Reset (aresetn low, synchronous): valid bits, counters and config cleared at once,
// no clearing pass; table contents are left as they are.
`timescale 1ns / 1ps

module mac_learning_bridge import mlb_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic                 cfg_wdata,     // forwarding_disabled
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // source_mac, dest_mac, ingress_port, frame_length
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // verdict, egress_port, source_learned, known_forward_count, flood_count,
    // passed_count, hardware_bytes, passed_bytes, zero pad
    output logic [M_TDATA_W-1:0] m_tdata
);

    cmd_t    cmd;
    status_t status;

    mlb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status)
    );

    mlb_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

FILE: hw/rtl/mlb_ram.sv
// mlb_ram: generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module mlb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/mlb_ctrl.sv
// mlb_ctrl: sequencer for capture, table scan and commit of one item
// depends on mlb_pkg
`timescale 1ns / 1ps

module mlb_ctrl import mlb_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_tvalid,
    output logic    s_tready,
    output logic    m_tvalid,
    input  logic    m_tready,
    output cmd_t    cmd,
    input  status_t status
);

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;
    logic   out_free;

    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (status.scan_last) begin
                    state_next = ST_LAST;
                end
            end
            ST_LAST: begin
                state_next = ST_COMMIT;
            end
            ST_COMMIT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
            end
            ST_LAST: begin
                cmd = '0;
            end
            ST_COMMIT: begin
                cmd.commit = out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    always_comb begin
        if (cmd.commit) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;

endmodule

FILE: hw/rtl/mlb_datapath.sv
// mlb_datapath: item registers, mac table with valid bits, scan compare, counters
// depends on mlb_pkg and mlb_ram
`timescale 1ns / 1ps

module mlb_datapath import mlb_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic                 cfg_wdata,
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic [M_TDATA_W-1:0] m_tdata,
    input  cmd_t                 cmd,
    output status_t              status
);

    // item fields
    mac_t             src_reg, dst_reg;
    port_t            port_reg;
    logic [LEN_W-1:0] len_reg;
    logic             fwd_dis_reg;

    // scan
    idx_t  addr_reg;
    logic  rd_valid_reg;
    idx_t  rd_idx_reg;
    logic  src_hit_reg, dst_hit_reg, free_hit_reg;
    idx_t  src_idx_reg, free_idx_reg;
    port_t dst_port_reg;
    logic [TABLE_ENTRIES-1:0] valid_reg;

    // totals and result
    cnt_t     known_reg, flood_reg, passed_reg, hw_bytes_reg, passed_bytes_reg;
    verdict_t verdict_reg, verdict_next;
    port_t    egress_reg, egress_next;
    logic     learned_reg, learned_next;

    logic [ENTRY_W-1:0] rd_data;
    mac_t  rd_mac;
    port_t rd_port;
    logic  rd_live;
    logic  pass, learn_ok, do_write, fwd;
    idx_t  learn_idx;

    mlb_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .aclk  (aclk),
        .we    (do_write),
        .waddr (learn_idx),
        .wdata ({port_reg, src_reg}),
        .re    (cmd.scan),
        .raddr (addr_reg),
        .rdata (rd_data)
    );

    assign rd_mac  = rd_data[MAC_W-1:0];
    assign rd_port = rd_data[ENTRY_W-1:MAC_W];
    assign rd_live = rd_valid_reg && valid_reg[rd_idx_reg];

    assign status.scan_last = (addr_reg == LAST_IDX);

    assign pass      = (len_reg < MIN_HEADER_BYTES) || fwd_dis_reg;
    assign learn_ok  = src_hit_reg || free_hit_reg;
    assign learn_idx = src_hit_reg ? src_idx_reg : free_idx_reg;
    assign do_write  = cmd.commit && !pass && learn_ok;
    assign fwd       = !pass && (dst_reg != src_reg) && dst_hit_reg
                       && (dst_port_reg != port_reg);

    always_comb begin
        egress_next = '0;
        if (pass) begin
            verdict_next = VERDICT_PASS;
            learned_next = src_hit_reg;
        end else if (fwd) begin
            verdict_next = VERDICT_FORWARD;
            learned_next = learn_ok;
            egress_next  = dst_port_reg;
        end else begin
            verdict_next = VERDICT_FLOOD;
            learned_next = learn_ok;
        end
    end

    // config register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_dis_reg <= 1'b0;
        end else if (cfg_we) begin
            fwd_dis_reg <= cfg_wdata;
        end
    end

    // item capture
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            src_reg  <= s_tdata[MAC_W-1:0];
            dst_reg  <= s_tdata[2*MAC_W-1:MAC_W];
            port_reg <= PORT_BITS'(s_tdata[2*MAC_W+IN_PORT_W-1:2*MAC_W]);
            len_reg  <= s_tdata[S_TDATA_W-1:2*MAC_W+IN_PORT_W];
        end
    end

    // scan address and read tracking
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            addr_reg     <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            rd_valid_reg <= cmd.scan;
            if (cmd.capture) begin
                addr_reg <= '0;
            end else if (cmd.scan) begin
                addr_reg <= addr_reg + idx_t'(1);
            end
        end
        rd_idx_reg <= addr_reg;
    end

    // first match for source, destination and free slot
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            src_hit_reg  <= 1'b0;
            dst_hit_reg  <= 1'b0;
            free_hit_reg <= 1'b0;
        end else if (rd_valid_reg) begin
            if (rd_live && rd_mac == src_reg && !src_hit_reg) begin
                src_hit_reg <= 1'b1;
                src_idx_reg <= rd_idx_reg;
            end
            if (rd_live && rd_mac == dst_reg && !dst_hit_reg) begin
                dst_hit_reg  <= 1'b1;
                dst_port_reg <= rd_port;
            end
            if (!valid_reg[rd_idx_reg] && !free_hit_reg) begin
                free_hit_reg <= 1'b1;
                free_idx_reg <= rd_idx_reg;
            end
        end
    end

    // valid bits and totals
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg        <= '0;
            known_reg        <= '0;
            flood_reg        <= '0;
            passed_reg       <= '0;
            hw_bytes_reg     <= '0;
            passed_bytes_reg <= '0;
        end else if (cmd.commit) begin
            if (do_write) begin
                valid_reg[learn_idx] <= 1'b1;
            end
            if (pass) begin
                passed_reg       <= passed_reg + cnt_t'(1);
                passed_bytes_reg <= passed_bytes_reg + CNT_W'(len_reg);
            end else begin
                hw_bytes_reg <= hw_bytes_reg + CNT_W'(len_reg);
                if (fwd) begin
                    known_reg <= known_reg + cnt_t'(1);
                end else begin
                    flood_reg <= flood_reg + cnt_t'(1);
                end
            end
        end
    end

    // result fields, totals stay put while the result waits
    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            verdict_reg <= verdict_next;
            egress_reg  <= egress_next;
            learned_reg <= learned_next;
        end
    end

    assign m_tdata = {
        (M_TDATA_W - M_USED_W)'(0),
        passed_bytes_reg,
        hw_bytes_reg,
        passed_reg,
        flood_reg,
        known_reg,
        learned_reg,
        8'(egress_reg),
        verdict_reg
    };

endmodule
